[rtl/assert_macros.svh]
// assertion helpers, clocked on clk and disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that holds at every clock edge
`define ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(name, expr, msg)
`define ASSERT_IMPLIES(name, ante, cons, msg)
`define ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

[rtl/gcrs_pkg.sv]
package gcrs_pkg;

  // field widths
  localparam int PIX_W = 11;
  localparam int VAL_W = 8;
  localparam int SUM_W = 20;
  localparam int CNT_W = 13;
  localparam int COL_W = 6;
  localparam int ROW_W = 11;
  localparam int CFG_W = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CELL_W = 7;

  // division steps, one quotient bit per stage
  localparam int DIV_STEPS = PIX_W;

  // queue and result buffer sizes
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_LEFT   = 3'd0,
    REG_REGION_TOP    = 3'd1,
    REG_REGION_WIDTH  = 3'd2,
    REG_REGION_HEIGHT = 3'd3,
    REG_CELL_WIDTH    = 3'd4,
    REG_CELL_HEIGHT   = 3'd5,
    REG_FRAME_WIDTH   = 3'd6,
    REG_FRAME_HEIGHT  = 3'd7
  } cfg_reg_t;

  // configuration register set
  typedef struct packed {
    logic [PIX_W-1:0]  region_left;
    logic [PIX_W-1:0]  region_top;
    logic [CFG_W-1:0]  region_width;
    logic [CFG_W-1:0]  region_height;
    logic [CELL_W-1:0] cell_width;
    logic [CELL_W-1:0] cell_height;
    logic [CFG_W-1:0]  frame_width;
    logic [CFG_W-1:0]  frame_height;
  } cfg_t;

  // one pixel moving through the division pipeline
  typedef struct packed {
    logic              ok;
    logic [PIX_W-1:0]  dx;
    logic [PIX_W-1:0]  dy;
    logic [CELL_W-1:0] rem_x;
    logic [CELL_W-1:0] rem_y;
    logic [PIX_W-1:0]  quo_x;
    logic [PIX_W-1:0]  quo_y;
    logic [VAL_W-1:0]  red;
    logic [VAL_W-1:0]  green;
    logic [VAL_W-1:0]  blue;
  } div_stage_t;

  // classified pixel handed to the accumulator side
  typedef struct packed {
    logic [PIX_W-1:0] cell_j;
    logic [ROW_W-1:0] band_i;
    logic             first;
    logic             last;
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
  } cell_req_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // one finished cell
  typedef struct packed {
    logic [SUM_W-1:0] sum_red;
    logic [SUM_W-1:0] sum_green;
    logic [SUM_W-1:0] sum_blue;
    logic [CNT_W-1:0] cell_pixels;
    logic [COL_W-1:0] cell_column;
    logic [ROW_W-1:0] cell_row;
  } result_t;

endpackage

[rtl/gcrs_queue.sv]
module gcrs_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gcrs_pkg::cell_req_t push_req,
  input  logic                pop,
  output gcrs_pkg::cell_req_t head_req,
  output gcrs_pkg::q_stat_t   stat
);
  import gcrs_pkg::*;

  cell_req_t            buffer [Q_DEPTH];
  logic [Q_PTR_W-1:0]   head;
  logic [Q_PTR_W-1:0]   tail;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  assign stat.full  = (count == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (count == '0);
  assign head_req   = buffer[head];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) tail <= tail + 1'b1;
      if (do_pop) head <= head + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) buffer[tail] <= push_req;
  end

endmodule

[rtl/gcrs_front.sv]
module gcrs_front #(
  parameter int MAX_CELLS_ACROSS = 64,
  parameter int MAX_CELL_SIDE    = 64,
  parameter int MAX_FRAME_SIDE   = 2048
) (
  input  logic                               clk,
  input  logic                               rst,
  input  gcrs_pkg::cfg_t                     cfg,
  input  logic                               hold,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [gcrs_pkg::PIX_W-1:0]         pixel_x,
  input  logic [gcrs_pkg::PIX_W-1:0]         pixel_y,
  input  logic [gcrs_pkg::VAL_W-1:0]         blue_value,
  input  logic [gcrs_pkg::VAL_W-1:0]         green_value,
  input  logic [gcrs_pkg::VAL_W-1:0]         red_value,
  input  logic                               mono_frame,
  output logic                               push,
  output gcrs_pkg::cell_req_t                push_req,
  input  gcrs_pkg::q_stat_t                  q_stat
);
  import gcrs_pkg::*;

  localparam int SIDE_W = ($clog2(MAX_FRAME_SIDE + 1) > CFG_W + 1) ?
                          $clog2(MAX_FRAME_SIDE + 1) : CFG_W + 1;
  localparam int CS_W   = ($clog2(MAX_CELL_SIDE + 1) > CELL_W) ?
                          $clog2(MAX_CELL_SIDE + 1) : CELL_W;
  localparam int JC_W   = ($clog2(MAX_CELLS_ACROSS + 1) > PIX_W) ?
                          $clog2(MAX_CELLS_ACROSS + 1) : PIX_W;
  localparam int SPAN_W = CFG_W + 1;

  div_stage_t           stg [DIV_STEPS+1];
  logic [DIV_STEPS:0]   stg_valid;
  div_stage_t           stg_in;
  div_stage_t           last_st;
  logic                 advance;
  logic                 in_accept;
  logic [SIDE_W-1:0]    x_end;
  logic [SIDE_W-1:0]    y_end;
  logic [SIDE_W-1:0]    x_lim;
  logic [SIDE_W-1:0]    y_lim;
  logic                 region_ok;
  logic                 size_ok;
  logic [SPAN_W-1:0]    span_x;
  logic [SPAN_W-1:0]    span_y;
  logic                 fits_x;
  logic                 fits_y;
  logic                 j_ok;
  logic                 keep;

  // one restoring division step on both coordinates
  function automatic div_stage_t div_step(input div_stage_t st,
                                          input logic [CELL_W-1:0] cw,
                                          input logic [CELL_W-1:0] ch,
                                          input int pos);
    div_stage_t      nx;
    logic [CELL_W:0] tx;
    logic [CELL_W:0] ty;
    nx = st;
    tx = {st.rem_x, st.dx[pos]};
    ty = {st.rem_y, st.dy[pos]};
    if (tx >= {1'b0, cw}) begin
      tx = tx - {1'b0, cw};
      nx.quo_x[pos] = 1'b1;
    end
    if (ty >= {1'b0, ch}) begin
      ty = ty - {1'b0, ch};
      nx.quo_y[pos] = 1'b1;
    end
    nx.rem_x = tx[CELL_W-1:0];
    nx.rem_y = ty[CELL_W-1:0];
    return nx;
  endfunction

  // region fit and cell size checks
  always_comb begin
    x_end = SIDE_W'(cfg.region_left) + SIDE_W'(cfg.region_width);
    y_end = SIDE_W'(cfg.region_top) + SIDE_W'(cfg.region_height);
    x_lim = (SIDE_W'(cfg.frame_width) > SIDE_W'(MAX_FRAME_SIDE)) ?
            SIDE_W'(MAX_FRAME_SIDE) : SIDE_W'(cfg.frame_width);
    y_lim = (SIDE_W'(cfg.frame_height) > SIDE_W'(MAX_FRAME_SIDE)) ?
            SIDE_W'(MAX_FRAME_SIDE) : SIDE_W'(cfg.frame_height);
    region_ok = (x_end <= x_lim) && (y_end <= y_lim);
    size_ok = (cfg.cell_width != '0) && (cfg.cell_height != '0) &&
              (CS_W'(cfg.cell_width) <= CS_W'(MAX_CELL_SIDE)) &&
              (CS_W'(cfg.cell_height) <= CS_W'(MAX_CELL_SIDE));
  end

  // load of the first stage from the request
  always_comb begin
    stg_in.ok    = region_ok && size_ok &&
                   (pixel_x >= cfg.region_left) && (pixel_y >= cfg.region_top);
    stg_in.dx    = pixel_x - cfg.region_left;
    stg_in.dy    = pixel_y - cfg.region_top;
    stg_in.rem_x = '0;
    stg_in.rem_y = '0;
    stg_in.quo_x = '0;
    stg_in.quo_y = '0;
    stg_in.blue  = blue_value;
    stg_in.green = mono_frame ? blue_value : green_value;
    stg_in.red   = mono_frame ? blue_value : red_value;
  end

  // classification at the end of the pipeline
  always_comb begin
    last_st = stg[DIV_STEPS];
    span_x  = SPAN_W'(last_st.dx) - SPAN_W'(last_st.rem_x) + SPAN_W'(cfg.cell_width);
    span_y  = SPAN_W'(last_st.dy) - SPAN_W'(last_st.rem_y) + SPAN_W'(cfg.cell_height);
    fits_x  = span_x <= SPAN_W'(cfg.region_width);
    fits_y  = span_y <= SPAN_W'(cfg.region_height);
    j_ok    = JC_W'(last_st.quo_x) < JC_W'(MAX_CELLS_ACROSS);
    keep    = last_st.ok && fits_x && fits_y && j_ok;

    push_req.cell_j = last_st.quo_x;
    push_req.band_i = last_st.quo_y;
    push_req.first  = (last_st.rem_x == '0) && (last_st.rem_y == '0);
    push_req.last   = ({1'b0, last_st.rem_x} + 1'b1 == {1'b0, cfg.cell_width}) &&
                      ({1'b0, last_st.rem_y} + 1'b1 == {1'b0, cfg.cell_height});
    push_req.red    = last_st.red;
    push_req.green  = last_st.green;
    push_req.blue   = last_st.blue;
  end

  // pipeline moves unless a kept pixel finds the queue full
  assign push      = stg_valid[DIV_STEPS] && keep;
  assign advance   = !(push && q_stat.full);
  assign in_ready  = advance && !hold;
  assign in_accept = in_valid && in_ready;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else if (advance) begin
      stg_valid <= {stg_valid[DIV_STEPS-1:0], in_accept};
    end
  end

  // first stage payload
  always_ff @(posedge clk) begin
    if (advance) stg[0] <= stg_in;
  end

  // division stages, most significant quotient bit first
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    always_ff @(posedge clk) begin
      if (advance) begin
        stg[s+1] <= div_step(stg[s], cfg.cell_width, cfg.cell_height, DIV_STEPS - 1 - s);
      end
    end
  end

endmodule

[rtl/gcrs_back.sv]
`include "assert_macros.svh"

module gcrs_back #(
  parameter int MAX_CELLS_ACROSS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  gcrs_pkg::cfg_t             cfg,
  input  gcrs_pkg::cell_req_t        head_req,
  input  gcrs_pkg::q_stat_t          q_stat,
  output logic                       pop,
  output logic                       clearing,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gcrs_pkg::SUM_W-1:0] sum_red,
  output logic [gcrs_pkg::SUM_W-1:0] sum_green,
  output logic [gcrs_pkg::SUM_W-1:0] sum_blue,
  output logic [gcrs_pkg::CNT_W-1:0] cell_pixels,
  output logic [gcrs_pkg::COL_W-1:0] cell_column,
  output logic [gcrs_pkg::ROW_W-1:0] cell_row
);
  import gcrs_pkg::*;

  localparam int IDX_W = (MAX_CELLS_ACROSS > 1) ? $clog2(MAX_CELLS_ACROSS) : 1;
  localparam int ACC_W = 3 * SUM_W;

  logic [ACC_W-1:0]       acc_mem [MAX_CELLS_ACROSS];
  logic [ACC_W-1:0]       rd_data;
  logic [IDX_W-1:0]       clr_addr;
  logic                   r_valid;
  cell_req_t              r_req;
  logic [IDX_W-1:0]       r_addr;
  logic                   fwd_valid;
  logic [IDX_W-1:0]       fwd_addr;
  logic [ACC_W-1:0]       fwd_data;
  logic [ACC_W-1:0]       old_acc;
  logic [ACC_W-1:0]       new_acc;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [ACC_W-1:0]       wr_data;
  logic [2*CELL_W-1:0]    pix_prod;
  result_t                res_new;
  logic                   res_push;
  logic                   out_pop;
  logic                   credit;
  result_t                out_buf [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   out_head;
  logic [OUT_PTR_W-1:0]   out_tail;
  logic [OUT_CNT_W-1:0]   out_count;

  // take a request only when the result buffer is sure to have room
  assign credit = (out_count + OUT_CNT_W'(r_valid)) < OUT_CNT_W'(OUT_DEPTH);
  assign pop    = !q_stat.empty && !clearing && credit;
  assign r_addr = r_req.cell_j[IDX_W-1:0];

  // clearing pass over the accumulators after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(MAX_CELLS_ACROSS - 1)) clearing <= 1'b0;
    end
  end

  // accumulate stage valid and request
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid   <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      r_valid   <= pop;
      fwd_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) r_req <= head_req;
    fwd_addr <= r_addr;
    fwd_data <= new_acc;
  end

  // read after a write to the same cell takes the written value
  always_comb begin
    old_acc = (fwd_valid && (fwd_addr == r_addr)) ? fwd_data : rd_data;
    if (r_req.first) begin
      new_acc = {SUM_W'(r_req.red), SUM_W'(r_req.green), SUM_W'(r_req.blue)};
    end else begin
      new_acc = {old_acc[3*SUM_W-1:2*SUM_W] + SUM_W'(r_req.red),
                 old_acc[2*SUM_W-1:SUM_W] + SUM_W'(r_req.green),
                 old_acc[SUM_W-1:0] + SUM_W'(r_req.blue)};
    end
  end

  // single write port shared by clearing and accumulation
  assign wr_en   = clearing || r_valid;
  assign wr_addr = clearing ? clr_addr : r_addr;
  assign wr_data = clearing ? '0 : new_acc;

  // accumulator memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) acc_mem[wr_addr] <= wr_data;
    if (pop) rd_data <= acc_mem[head_req.cell_j[IDX_W-1:0]];
  end

  // finished cell
  assign pix_prod = (2*CELL_W)'(cfg.cell_width) * (2*CELL_W)'(cfg.cell_height);

  always_comb begin
    res_new.sum_red     = new_acc[3*SUM_W-1:2*SUM_W];
    res_new.sum_green   = new_acc[2*SUM_W-1:SUM_W];
    res_new.sum_blue    = new_acc[SUM_W-1:0];
    res_new.cell_pixels = pix_prod[CNT_W-1:0];
    res_new.cell_column = r_req.cell_j[COL_W-1:0];
    res_new.cell_row    = r_req.band_i;
  end

  assign res_push  = r_valid && r_req.last;
  assign out_valid = (out_count != '0);
  assign out_pop   = out_valid && out_ready;

  // result buffer pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      out_head  <= '0;
      out_tail  <= '0;
      out_count <= '0;
    end else begin
      if (res_push) out_tail <= out_tail + 1'b1;
      if (out_pop) out_head <= out_head + 1'b1;
      if (res_push && !out_pop) out_count <= out_count + 1'b1;
      else if (out_pop && !res_push) out_count <= out_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) out_buf[out_tail] <= res_new;
  end

  // result port
  assign sum_red     = out_buf[out_head].sum_red;
  assign sum_green   = out_buf[out_head].sum_green;
  assign sum_blue    = out_buf[out_head].sum_blue;
  assign cell_pixels = out_buf[out_head].cell_pixels;
  assign cell_column = out_buf[out_head].cell_column;
  assign cell_row    = out_buf[out_head].cell_row;

  // checks
  `ASSERT_ALWAYS(a_credit_room, (out_count + OUT_CNT_W'(r_valid)) <= OUT_CNT_W'(OUT_DEPTH), "result buffer overrun")
  `ASSERT_IMPLIES(a_no_work_in_clear, clearing, !r_valid && !fwd_valid, "accumulate during clearing")
  `ASSERT_NEXT(a_fwd_follows_write, r_valid, fwd_valid && (fwd_addr == $past(r_addr)), "forward lost")

endmodule

[rtl/grid_cell_rgb_sum.sv]
// channel  dir  handshake              payload
// pixel    in   in_valid / in_ready    pixel_x pixel_y blue_value green_value red_value mono_frame
// cell     out  out_valid / out_ready  sum_red sum_green sum_blue cell_pixels cell_column cell_row
// config   in   cfg_write_en           cfg_index cfg_data
//
// one pixel request per cycle sustained while in_ready is high; a cell result
// leaves after its last pixel passes the 11-stage coordinate divider, the queue
// and the accumulator read-modify-write stage
// after reset a clearing pass zeroes all MAX_CELLS_ACROSS accumulators,
// in_ready stays low meanwhile, config writes are taken
// out_ready low fills a 4-entry result buffer, then a 4-entry queue, then the
// divider pipeline, and in_ready drops
module grid_cell_rgb_sum #(
  parameter int MAX_CELLS_ACROSS = 64,
  parameter int MAX_CELL_SIDE    = 64,
  parameter int MAX_FRAME_SIDE   = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [gcrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gcrs_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gcrs_pkg::PIX_W-1:0]     pixel_x,
  input  logic [gcrs_pkg::PIX_W-1:0]     pixel_y,
  input  logic [gcrs_pkg::VAL_W-1:0]     blue_value,
  input  logic [gcrs_pkg::VAL_W-1:0]     green_value,
  input  logic [gcrs_pkg::VAL_W-1:0]     red_value,
  input  logic                           mono_frame,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gcrs_pkg::SUM_W-1:0]     sum_red,
  output logic [gcrs_pkg::SUM_W-1:0]     sum_green,
  output logic [gcrs_pkg::SUM_W-1:0]     sum_blue,
  output logic [gcrs_pkg::CNT_W-1:0]     cell_pixels,
  output logic [gcrs_pkg::COL_W-1:0]     cell_column,
  output logic [gcrs_pkg::ROW_W-1:0]     cell_row
);
  import gcrs_pkg::*;

  cfg_t       cfg;
  logic       push;
  cell_req_t  push_req;
  cell_req_t  head_req;
  q_stat_t    q_stat;
  logic       pop;
  logic       clearing;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.region_left   <= '0;
      cfg.region_top    <= '0;
      cfg.region_width  <= '0;
      cfg.region_height <= '0;
      cfg.cell_width    <= CELL_W'(8);
      cfg.cell_height   <= CELL_W'(8);
      cfg.frame_width   <= CFG_W'(640);
      cfg.frame_height  <= CFG_W'(480);
    end else if (cfg_write_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REGION_LEFT:   cfg.region_left   <= cfg_data[PIX_W-1:0];
        REG_REGION_TOP:    cfg.region_top    <= cfg_data[PIX_W-1:0];
        REG_REGION_WIDTH:  cfg.region_width  <= cfg_data;
        REG_REGION_HEIGHT: cfg.region_height <= cfg_data;
        REG_CELL_WIDTH:    cfg.cell_width    <= cfg_data[CELL_W-1:0];
        REG_CELL_HEIGHT:   cfg.cell_height   <= cfg_data[CELL_W-1:0];
        REG_FRAME_WIDTH:   cfg.frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  cfg.frame_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pixel classification and coordinate division
  gcrs_front #(
    .MAX_CELLS_ACROSS (MAX_CELLS_ACROSS),
    .MAX_CELL_SIDE    (MAX_CELL_SIDE),
    .MAX_FRAME_SIDE   (MAX_FRAME_SIDE)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .hold        (clearing),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .blue_value  (blue_value),
    .green_value (green_value),
    .red_value   (red_value),
    .mono_frame  (mono_frame),
    .push        (push),
    .push_req    (push_req),
    .q_stat      (q_stat)
  );

  // decoupling queue
  gcrs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .head_req (head_req),
    .stat     (q_stat)
  );

  // accumulators and result buffer
  gcrs_back #(
    .MAX_CELLS_ACROSS (MAX_CELLS_ACROSS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_req    (head_req),
    .q_stat      (q_stat),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sum_red     (sum_red),
    .sum_green   (sum_green),
    .sum_blue    (sum_blue),
    .cell_pixels (cell_pixels),
    .cell_column (cell_column),
    .cell_row    (cell_row)
  );

endmodule
